// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the button detector RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BCHD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define BCHD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BCHD_ASSERT(lbl, clk, rst_n, prop)
`define BCHD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/bchd_pkg.sv =====
// ---------------------------------------------------------------------------
// bchd_pkg
// Types and constants for the button click and hold detector.
// ---------------------------------------------------------------------------
package bchd_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int CFG_W         = 16;
	localparam int IDX_W         = 2;

	localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [IDX_W-1:0] REG_HOLD     = 2'd1;
	localparam logic [IDX_W-1:0] REG_MULTI    = 2'd2;
	localparam logic [IDX_W-1:0] REG_POLARITY = 2'd3;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_W-1:0] HOLD_RST     = 16'd1000;
	localparam logic [CFG_W-1:0] MULTI_RST    = 16'd400;
	localparam logic             POLARITY_RST = 1'b1;

	localparam logic [1:0] CLICK_MAX = 2'd3;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_PRESS   = 3'd1,
		EV_RELEASE = 3'd2,
		EV_HOLD    = 3'd3,
		EV_CLICK   = 3'd4,
		EV_DOUBLE  = 3'd5,
		EV_TRIPLE  = 3'd6
	} event_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ticks;
		logic [CFG_W-1:0] hold_ticks;
		logic [CFG_W-1:0] multi_click_ticks;
		logic             active_low;
	} cfg_t;

	typedef struct packed {
		event_t     ev;
		logic       pressed;
		logic [1:0] click_count;
	} result_t;

endpackage

// ===== rtl/bchd_core.sv =====
// ---------------------------------------------------------------------------
// bchd_core
// Tick counter, debounce and click/hold state machine; one tick per step.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bchd_core #(
	parameter int TIME_BITS = bchd_pkg::TIME_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             raw,
	input  bchd_pkg::cfg_t   cfg,
	output bchd_pkg::result_t res
);

	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_PRESSED = 2'd1,
		ST_WAITING = 2'd2,
		ST_HELD    = 2'd3
	} state_t;

	logic [TIME_BITS-1:0] tick_q, last_change_q, press_q, release_q;
	logic                 last_raw_q, stable_q, hold_done_q;
	logic [1:0]           clicks_q;
	state_t               state_q;

	logic [TIME_BITS-1:0] now, change_n, press_n, release_n;
	logic                 reading, stable_n, hold_done_n;
	logic [1:0]           clicks_n;
	state_t               state_n;
	bchd_pkg::event_t     ev_n;

	always_comb begin
		logic [TIME_BITS-1:0] el_db, el_rel_old, el_hold, el_rel;
		reading     = raw ^ cfg.active_low;
		now         = tick_q + TIME_BITS'(1);
		change_n    = (reading != last_raw_q) ? now : last_change_q;
		press_n     = press_q;
		release_n   = release_q;
		stable_n    = stable_q;
		hold_done_n = hold_done_q;
		clicks_n    = clicks_q;
		state_n     = state_q;
		ev_n        = bchd_pkg::EV_NONE;
		el_db       = now - change_n;
		el_rel_old  = now - release_q;
		el_hold     = '0;
		el_rel      = '0;
		if (el_db >= TIME_BITS'(cfg.debounce_ticks)) begin
			if (reading != stable_q) begin
				stable_n = reading;
				if (reading) begin
					press_n     = now;
					hold_done_n = 1'b0;
					if (state_q == ST_WAITING &&
					    el_rel_old <= TIME_BITS'(cfg.multi_click_ticks)) begin
						if (clicks_q != bchd_pkg::CLICK_MAX) begin
							clicks_n = clicks_q + 2'd1;
						end
					end else begin
						clicks_n = 2'd1;
					end
					ev_n    = bchd_pkg::EV_PRESS;
					state_n = ST_PRESSED;
				end else begin
					ev_n = bchd_pkg::EV_RELEASE;
					if (state_q == ST_HELD) begin
						clicks_n = 2'd0;
						state_n  = ST_IDLE;
					end else begin
						release_n = now;
						state_n   = ST_WAITING;
					end
				end
			end
			el_hold = now - press_n;
			if (state_n == ST_PRESSED && !hold_done_n &&
			    el_hold >= TIME_BITS'(cfg.hold_ticks)) begin
				ev_n        = bchd_pkg::EV_HOLD;
				hold_done_n = 1'b1;
				clicks_n    = 2'd0;
				state_n     = ST_HELD;
			end
			el_rel = now - release_n;
			if (state_n == ST_WAITING && el_rel > TIME_BITS'(cfg.multi_click_ticks)) begin
				case (clicks_n)
					2'd1:    ev_n = bchd_pkg::EV_CLICK;
					2'd2:    ev_n = bchd_pkg::EV_DOUBLE;
					2'd3:    ev_n = bchd_pkg::EV_TRIPLE;
					default: ;
				endcase
				clicks_n = 2'd0;
				state_n  = ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= '0;
			last_raw_q    <= 1'b0;
			stable_q      <= 1'b0;
			last_change_q <= '0;
			press_q       <= '0;
			release_q     <= '0;
			state_q       <= ST_IDLE;
			clicks_q      <= 2'd0;
			hold_done_q   <= 1'b0;
		end else if (step) begin
			tick_q        <= now;
			last_raw_q    <= reading;
			stable_q      <= stable_n;
			last_change_q <= change_n;
			press_q       <= press_n;
			release_q     <= release_n;
			state_q       <= state_n;
			clicks_q      <= clicks_n;
			hold_done_q   <= hold_done_n;
		end
	end

	assign res.ev          = ev_n;
	assign res.pressed     = stable_n;
	assign res.click_count = clicks_n;

	`BCHD_ASSERT(a_pressed_level, clk, arst_n,
		(state_q == ST_PRESSED || state_q == ST_HELD) |-> stable_q)
	`BCHD_ASSERT(a_waiting_level, clk, arst_n, (state_q == ST_WAITING) |-> !stable_q)
	`BCHD_ASSERT(a_no_clicks, clk, arst_n,
		(state_q == ST_IDLE || state_q == ST_HELD) |-> (clicks_q == 2'd0))

endmodule

// ===== rtl/button_click_hold_detector.sv =====
// ---------------------------------------------------------------------------
// button_click_hold_detector
// Debounces a sampled button level and reports press, release, hold and
// single, double or triple click events, one result per tick.
// ---------------------------------------------------------------------------
//  channel  signals                                   direction
//  in       in_valid, in_stall, raw_level             tick transfer in
//  out      out_valid, out_stall, event_res,
//           pressed, click_count                      result transfer out
//  cfg      cfg_we, cfg_index, cfg_wdata              register write
//
//  one tick per cycle while the result is not stalled; input register, step logic, result register
//  an input transfer is held in the input register, then the result register, before result valid
//  a stalled result holds while one more tick waits in the input register
//  reset: button released, machine idle, registers at defaults
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module button_click_hold_detector #(
	parameter int TIME_BITS = bchd_pkg::TIME_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       raw_level,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [2:0]                 event_res,
	output logic                       pressed,
	output logic [1:0]                 click_count,
	input  logic                       cfg_we,
	input  logic [bchd_pkg::IDX_W-1:0] cfg_index,
	input  logic [bchd_pkg::CFG_W-1:0] cfg_wdata
);

	bchd_pkg::cfg_t    cfg_q;
	bchd_pkg::result_t res_c, res_q;
	logic              valid_s1, raw_s1, out_valid_q, load, accept;

	assign load     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !load;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks    <= bchd_pkg::DEBOUNCE_RST;
			cfg_q.hold_ticks        <= bchd_pkg::HOLD_RST;
			cfg_q.multi_click_ticks <= bchd_pkg::MULTI_RST;
			cfg_q.active_low        <= bchd_pkg::POLARITY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bchd_pkg::REG_DEBOUNCE: cfg_q.debounce_ticks    <= cfg_wdata;
				bchd_pkg::REG_HOLD:     cfg_q.hold_ticks        <= cfg_wdata;
				bchd_pkg::REG_MULTI:    cfg_q.multi_click_ticks <= cfg_wdata;
				bchd_pkg::REG_POLARITY: cfg_q.active_low        <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1 <= raw_level;
		end
		if (load) begin
			res_q <= res_c;
		end
	end

	bchd_core #(
		.TIME_BITS(TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (load),
		.raw    (raw_s1),
		.cfg    (cfg_q),
		.res    (res_c)
	);

	assign out_valid   = out_valid_q;
	assign event_res   = res_q.ev;
	assign pressed     = res_q.pressed;
	assign click_count = res_q.click_count;

	`BCHD_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> (valid_s1 && out_valid_q && out_stall))
	`BCHD_ASSERT_NEXT(a_hold_result, clk, arst_n, load && res_c.ev == bchd_pkg::EV_HOLD,
		res_q.pressed && res_q.click_count == 2'd0)
	`BCHD_ASSERT_NEXT(a_click_result, clk, arst_n,
		load && (res_c.ev == bchd_pkg::EV_CLICK || res_c.ev == bchd_pkg::EV_DOUBLE ||
		res_c.ev == bchd_pkg::EV_TRIPLE),
		!res_q.pressed && res_q.click_count == 2'd0)

endmodule
